// ===== rtl/core/i2cseq_pkg.sv =====
`default_nettype none

package i2cseq_pkg;

    localparam int BUF_DEPTH_DEF = 16;
    localparam int MAX_FETCH     = 16;

    localparam int OP_W          = 3;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 32;

    localparam logic [OP_W-1:0] OP_START_READ  = 3'd0;
    localparam logic [OP_W-1:0] OP_START_WRITE = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD        = 3'd2;
    localparam logic [OP_W-1:0] OP_EVENT       = 3'd3;
    localparam logic [OP_W-1:0] OP_FETCH       = 3'd4;

    localparam logic [4:0] CMD_START = 5'h01;
    localparam logic [4:0] CMD_STOP  = 5'h02;
    localparam logic [4:0] CMD_READ  = 5'h04;
    localparam logic [4:0] CMD_WRITE = 5'h08;
    localparam logic [4:0] CMD_NACK  = 5'h10;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CTRL,
        PH_DATA,
        PH_LAST,
        PH_READY
    } t_phase;

    typedef enum logic [1:0] {
        ST_WAIT_IN,
        ST_EXEC,
        ST_OUT,
        ST_FETCH_RD
    } t_state;

    typedef struct packed {
        logic accept;
        logic exec;
        logic fetch_load;
        logic fetch_addr;
    } t_ctl_cmd;

    typedef struct packed {
        logic more;
    } t_dp_status;

    typedef struct packed {
        logic       busy;
        logic       last;
        logic       fv;
        logic [7:0] fb;
        logic       done;
        logic       err;
        logic [7:0] cb;
        logic [4:0] cc;
        logic       cv;
        logic       acc;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/i2cseq_ram.sv =====
`default_nettype none

module i2cseq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/i2cseq_ctrl.sv =====
`default_nettype none

module i2cseq_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_out_ready,
    input  wire i2cseq_pkg::t_dp_status i_status,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    output i2cseq_pkg::t_ctl_cmd        o_cmd
);

    i2cseq_pkg::t_state r_state;
    i2cseq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2cseq_pkg::ST_WAIT_IN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            i2cseq_pkg::ST_WAIT_IN: begin
                if (i_in_valid) n_state = i2cseq_pkg::ST_EXEC;
            end
            i2cseq_pkg::ST_EXEC: begin
                n_state = i2cseq_pkg::ST_OUT;
            end
            i2cseq_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    n_state = i_status.more ? i2cseq_pkg::ST_FETCH_RD
                                            : i2cseq_pkg::ST_WAIT_IN;
                end
            end
            i2cseq_pkg::ST_FETCH_RD: begin
                n_state = i2cseq_pkg::ST_OUT;
            end
            default: n_state = i2cseq_pkg::ST_WAIT_IN;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == i2cseq_pkg::ST_WAIT_IN);
        o_out_valid = (r_state == i2cseq_pkg::ST_OUT);
        o_cmd.accept     = (r_state == i2cseq_pkg::ST_WAIT_IN) && i_in_valid;
        o_cmd.exec       = (r_state == i2cseq_pkg::ST_EXEC);
        o_cmd.fetch_load = (r_state == i2cseq_pkg::ST_FETCH_RD);
        o_cmd.fetch_addr = (r_state == i2cseq_pkg::ST_OUT);
    end

endmodule

`default_nettype wire

// ===== rtl/core/i2cseq_dp.sv =====
`default_nettype none

module i2cseq_dp #(
    parameter int BUF_DEPTH = i2cseq_pkg::BUF_DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire i2cseq_pkg::t_ctl_cmd                 i_cmd,
    input  wire logic [i2cseq_pkg::IN_TDATA_W-1:0]    i_tdata,
    input  wire logic [i2cseq_pkg::OP_W-1:0]          i_op,
    output i2cseq_pkg::t_dp_status                    o_status,
    output i2cseq_pkg::t_result                       o_result
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int PW = $clog2(BUF_DEPTH + 1);

    // latched input beat
    logic [i2cseq_pkg::OP_W-1:0] r_op;
    logic [6:0]                  r_addr;
    logic [4:0]                  r_len;
    logic [3:0]                  r_idx;
    logic [7:0]                  r_wbyte;
    logic                        r_nack;
    logic                        r_arb;
    logic                        r_tip;
    logic [7:0]                  r_rx;

    i2cseq_pkg::t_phase r_phase, n_phase;
    logic               r_reading, n_reading;
    logic [4:0]         r_rem, n_rem;
    logic [PW-1:0]      r_ptr, n_ptr;
    logic [PW-1:0]      r_fcnt, n_fcnt;
    logic [PW-1:0]      r_fidx, n_fidx;
    i2cseq_pkg::t_result r_res, n_res;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    i2cseq_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (i_cmd.fetch_addr) begin
            ram_raddr = AW'(r_fidx);
        end else if (i_op == i2cseq_pkg::OP_FETCH) begin
            ram_raddr = '0;
        end else begin
            ram_raddr = AW'(r_ptr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_op;
            r_addr  <= i_tdata[6:0];
            r_len   <= i_tdata[11:7];
            r_idx   <= i_tdata[15:12];
            r_wbyte <= i_tdata[23:16];
            r_nack  <= i_tdata[24];
            r_arb   <= i_tdata[25];
            r_tip   <= i_tdata[26];
            r_rx    <= i_tdata[34:27];
        end
        if (i_cmd.exec || i_cmd.fetch_load) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= i2cseq_pkg::PH_IDLE;
            r_reading <= 1'b0;
            r_rem     <= '0;
            r_ptr     <= '0;
            r_fcnt    <= '0;
            r_fidx    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_reading <= n_reading;
            r_rem     <= n_rem;
            r_ptr     <= n_ptr;
            r_fcnt    <= n_fcnt;
            r_fidx    <= n_fidx;
        end
    end

    always_comb begin
        logic          rd;
        logic          ptr_ok;
        logic          fin;
        logic [4:0]    rem_dec;
        logic [PW-1:0] cnt;

        n_phase   = r_phase;
        n_reading = r_reading;
        n_rem     = r_rem;
        n_ptr     = r_ptr;
        n_fcnt    = r_fcnt;
        n_fidx    = r_fidx;
        n_res     = '0;
        ram_we    = 1'b0;
        ram_waddr = AW'(r_ptr);
        ram_wdata = r_rx;

        rd      = (r_op == i2cseq_pkg::OP_START_READ);
        ptr_ok  = int'(r_ptr) < BUF_DEPTH;
        fin     = (r_rem <= 5'd1);
        rem_dec = (r_rem != 5'd0) ? (r_rem - 5'd1) : r_rem;
        cnt     = (int'(r_ptr) > i2cseq_pkg::MAX_FETCH) ? PW'(i2cseq_pkg::MAX_FETCH) : r_ptr;

        if (i_cmd.exec) begin
            n_fcnt     = '0;
            n_fidx     = PW'(1);
            n_res.last = 1'b1;
            unique case (r_op)
                i2cseq_pkg::OP_START_READ, i2cseq_pkg::OP_START_WRITE: begin
                    if (r_phase == i2cseq_pkg::PH_IDLE) begin
                        if (rd && r_len == 5'd0) begin
                            n_res.acc = 1'b1;
                        end else if (int'(r_len) <= BUF_DEPTH) begin
                            n_res.acc = 1'b1;
                            n_res.cv  = 1'b1;
                            n_reading = rd;
                            n_rem     = r_len;
                            n_ptr     = '0;
                            if (r_len == 5'd0) begin
                                // zero-length write: address only, then STOP
                                n_res.cc = i2cseq_pkg::CMD_WRITE | i2cseq_pkg::CMD_START
                                         | i2cseq_pkg::CMD_STOP;
                                n_res.cb = {r_addr, 1'b0};
                                n_phase  = i2cseq_pkg::PH_LAST;
                            end else begin
                                n_res.cc = i2cseq_pkg::CMD_WRITE | i2cseq_pkg::CMD_START;
                                n_res.cb = {r_addr, rd};
                                n_phase  = i2cseq_pkg::PH_CTRL;
                            end
                        end
                    end
                end
                i2cseq_pkg::OP_LOAD: begin
                    if (r_phase == i2cseq_pkg::PH_IDLE && int'(r_idx) < BUF_DEPTH) begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(r_idx);
                        ram_wdata = r_wbyte;
                        n_res.acc = 1'b1;
                    end
                end
                i2cseq_pkg::OP_EVENT: begin
                    if ((r_nack && !r_reading) || r_arb) begin
                        n_phase   = i2cseq_pkg::PH_IDLE;
                        n_res.cv  = 1'b1;
                        n_res.cc  = i2cseq_pkg::CMD_STOP;
                        n_res.err = 1'b1;
                    end else if (!r_tip) begin
                        unique case (r_phase)
                            i2cseq_pkg::PH_IDLE: begin
                                // spurious event
                                n_res.cv  = 1'b1;
                                n_res.cc  = i2cseq_pkg::CMD_STOP;
                                n_res.err = 1'b1;
                            end
                            i2cseq_pkg::PH_CTRL, i2cseq_pkg::PH_DATA: begin
                                n_res.cv = 1'b1;
                                if (r_reading) begin
                                    if (r_phase == i2cseq_pkg::PH_DATA && ptr_ok) begin
                                        ram_we = 1'b1;
                                        n_ptr  = r_ptr + PW'(1);
                                    end
                                    n_res.cc = fin ? (i2cseq_pkg::CMD_READ
                                                      | i2cseq_pkg::CMD_NACK
                                                      | i2cseq_pkg::CMD_STOP)
                                                   : i2cseq_pkg::CMD_READ;
                                end else begin
                                    if (ptr_ok) begin
                                        n_res.cb = ram_rdata;
                                        n_ptr    = r_ptr + PW'(1);
                                    end
                                    n_res.cc = fin ? (i2cseq_pkg::CMD_WRITE
                                                      | i2cseq_pkg::CMD_STOP)
                                                   : i2cseq_pkg::CMD_WRITE;
                                end
                                n_rem   = rem_dec;
                                n_phase = (rem_dec == 5'd0) ? i2cseq_pkg::PH_LAST
                                                            : i2cseq_pkg::PH_DATA;
                            end
                            i2cseq_pkg::PH_LAST: begin
                                if (r_reading) begin
                                    if (ptr_ok) begin
                                        ram_we = 1'b1;
                                        n_ptr  = r_ptr + PW'(1);
                                    end
                                    n_phase = i2cseq_pkg::PH_READY;
                                end else begin
                                    n_phase = i2cseq_pkg::PH_IDLE;
                                end
                                n_res.done = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                i2cseq_pkg::OP_FETCH: begin
                    if (r_phase == i2cseq_pkg::PH_READY) begin
                        n_phase   = i2cseq_pkg::PH_IDLE;
                        n_res.acc = 1'b1;
                        if (cnt != '0) begin
                            n_res.fb   = ram_rdata;
                            n_res.fv   = 1'b1;
                            n_res.last = (cnt == PW'(1));
                            n_fcnt     = cnt;
                        end
                    end
                end
                default: ;
            endcase
            n_res.busy = (n_phase != i2cseq_pkg::PH_IDLE);
        end else if (i_cmd.fetch_load) begin
            n_res.acc  = 1'b1;
            n_res.fv   = 1'b1;
            n_res.fb   = ram_rdata;
            n_res.last = ((r_fidx + PW'(1)) == r_fcnt);
            n_fidx     = r_fidx + PW'(1);
        end
    end

    assign o_status.more = (r_fidx < r_fcnt);
    assign o_result      = r_res;

endmodule

`default_nettype wire

// ===== rtl/core/i2c_async_transfer_sequencer.sv =====
// I2C transfer sequencer in front of a byte-level I2C engine.
// Input channel s_axis: one beat per operation. tuser carries the operation
// (start read, start write, load buffer byte, engine event, fetch); tdata
// carries address, length, buffer slot, write byte and the engine status.
// Output channel m_axis: one beat per operation, or one beat per read byte
// for a fetch with data; tlast marks the final beat of an operation.
// An accepted beat is executed in the EXEC state and its result is shown in
// the OUT state. The block holds one operation at a time: s_axis_tready is
// high only while no result is pending, so a new operation waits until the
// last result has left, including any output stall. Each further fetch beat
// passes through the FETCH_RD state for the registered byte buffer RAM read.
// When m_axis_tready is low the result beat is held stable and no input is
// taken. Reset (i_rst_n low, synchronous) returns the sequencer to idle with
// no output pending; the byte buffer contents are not cleared.
`default_nettype none

module i2c_async_transfer_sequencer #(
    parameter int BUF_DEPTH = i2cseq_pkg::BUF_DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [6:0] target_address, [11:7] length, [15:12] buffer_index,
    // [23:16] write_byte, [24] ack_missing, [25] arbitration_lost,
    // [26] transfer_in_progress, [34:27] received_byte
    input  wire logic [i2cseq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [2:0] operation
    input  wire logic [i2cseq_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [0] accepted, [1] command_valid, [6:2] command_code, [14:7] command_byte,
    // [15] error, [16] done_res, [24:17] fetched_byte, [25] busy_res
    output logic      [i2cseq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] fetched_valid
    output logic      [0:0]                           m_axis_tuser,
    output logic                                      m_axis_tlast
);

    i2cseq_pkg::t_ctl_cmd   cmd;
    i2cseq_pkg::t_dp_status status;
    i2cseq_pkg::t_result    res;

    i2cseq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    i2cseq_dp #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_tdata  (s_axis_tdata),
        .i_op     (s_axis_tuser),
        .o_status (status),
        .o_result (res)
    );

    assign m_axis_tdata = {6'd0, res.busy, res.fb, res.done, res.err,
                           res.cb, res.cc, res.cv, res.acc};
    assign m_axis_tuser = res.fv;
    assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
